// ----- hw/rtl/gflc_pkg.sv -----
// ----------------------------------------------------------------------------
// gflc_pkg
// Shared widths, register codes and controller/datapath handshake types for
// the grid frequency load controller.
// ----------------------------------------------------------------------------
package gflc_pkg;

	// Field widths
	localparam int SLOT_W   = 6;
	localparam int SPEED_W  = 24;
	localparam int GAIN_W   = 24;
	localparam int MAXADJ_W = 16;
	localparam int ADJ_W    = 17;

	// Accumulator and divider widths
	localparam int SUM_W     = 31;
	localparam int CNT_W     = 7;
	localparam int DIVD_W    = 30;
	localparam int MEAN_W    = 25;
	localparam int PROD_W    = MEAN_W + GAIN_W;
	localparam int FRAC_W    = 16;
	localparam int MAG_W     = PROD_W - FRAC_W;
	localparam int DIV_STEPS = DIVD_W;
	localparam int STEP_W    = 5;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIM = 1'b1;

	localparam logic signed [GAIN_W-1:0] GAIN_RST   = 24'sd65536;
	localparam logic [MAXADJ_W-1:0]      MAXADJ_RST = 16'd19661;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic read;
		logic update;
		logic prep;
		logic div_step;
		logic mult;
		logic absv;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic count_zero;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- hw/rtl/gflc_ifs.sv -----
// ----------------------------------------------------------------------------
// gflc channel interfaces
// Valid/ready channels for measurements, results and register writes.
// ----------------------------------------------------------------------------
interface gflc_meas_if;
	import gflc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [SLOT_W-1:0]         slot_index;
	logic                      breaker_open;
	logic signed [SPEED_W-1:0] rotor_speed;

	modport source (output valid, slot_index, breaker_open, rotor_speed, input ready);
	modport sink   (input valid, slot_index, breaker_open, rotor_speed, output ready);
endinterface

interface gflc_res_if;
	import gflc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [ADJ_W-1:0] adjustment;
	logic                    changed;

	modport source (output valid, adjustment, changed, input ready);
	modport sink   (input valid, adjustment, changed, output ready);
endinterface

interface gflc_cfg_if;
	import gflc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/gflc_ram.sv -----
// ----------------------------------------------------------------------------
// gflc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gflc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/gflc_ctrl.sv -----
// ----------------------------------------------------------------------------
// gflc_ctrl
// Sequencer: table read, table update, divide loop, multiply, magnitude and
// result load.
// ----------------------------------------------------------------------------
module gflc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               meas_fire,
	input  gflc_pkg::dp_stat_t stat,
	output gflc_pkg::dp_cmd_t  cmd,
	output logic               meas_ready
);
	import gflc_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_READ   = 8'b0000_0010,
		ST_UPDATE = 8'b0000_0100,
		ST_PREP   = 8'b0000_1000,
		ST_DIVIDE = 8'b0001_0000,
		ST_MULT   = 8'b0010_0000,
		ST_ABS    = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (meas_fire) state_d = ST_READ;
			end
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_PREP;
			ST_PREP: begin
				state_d = stat.count_zero ? ST_EMIT : ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (step_q == LAST_STEP) state_d = ST_MULT;
			end
			ST_MULT: state_d = ST_ABS;
			ST_ABS:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PREP) begin
				step_q <= '0;
			end else if (state_q == ST_DIVIDE) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Decode commands
	always_comb begin
		cmd          = '0;
		cmd.capture  = meas_fire;
		cmd.read     = (state_q == ST_READ);
		cmd.update   = (state_q == ST_UPDATE);
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIVIDE);
		cmd.mult     = (state_q == ST_MULT);
		cmd.absv     = (state_q == ST_ABS);
		cmd.emit     = (state_q == ST_EMIT) && stat.out_free;
	end

	assign meas_ready = (state_q == ST_IDLE);

endmodule

// ----- hw/rtl/gflc_dp.sv -----
// ----------------------------------------------------------------------------
// gflc_dp
// Datapath: speed table, running sum and count, restoring divider,
// gain multiplier, clamp and output register.
// ----------------------------------------------------------------------------
module gflc_dp #(
	parameter int GENERATORS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gflc_pkg::dp_cmd_t                cmd,
	output gflc_pkg::dp_stat_t               stat,
	input  logic [gflc_pkg::SLOT_W-1:0]      slot_index,
	input  logic                             breaker_open,
	input  logic signed [gflc_pkg::SPEED_W-1:0] rotor_speed,
	input  logic                             cfg_fire,
	input  logic [gflc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gflc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             res_ready,
	output logic                             res_valid,
	output logic signed [gflc_pkg::ADJ_W-1:0] res_adjustment,
	output logic                             res_changed
);
	import gflc_pkg::*;

	localparam int AW = (GENERATORS > 1) ? $clog2(GENERATORS) : 1;

	// Captured measurement
	logic [SLOT_W-1:0]         slot_q;
	logic                      open_q;
	logic signed [SPEED_W-1:0] speed_q;

	// Table state
	logic [GENERATORS-1:0]     present_q;
	logic [GENERATORS-1:0]     written_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]          cnt_q;

	// Configuration
	logic signed [GAIN_W-1:0]  gain_q;
	logic [MAXADJ_W-1:0]       max_q;

	// Divider, multiplier, magnitude
	logic                      sum_neg_q;
	logic [CNT_W-1:0]          rem_q;
	logic [DIVD_W-1:0]         quo_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      neg_q;
	logic [MAG_W-1:0]          mag_q;

	// Output
	logic                      res_valid_q;
	logic signed [ADJ_W-1:0]   res_adj_q;
	logic                      res_changed_q;
	logic signed [ADJ_W-1:0]   last_q;

	logic                      in_range;
	logic [AW-1:0]             addr;
	logic [SPEED_W-1:0]        rdata;
	logic signed [SPEED_W-1:0] old_speed;
	logic                      pres_old;
	logic signed [SUM_W-1:0]   sum_rm;
	logic [CNT_W-1:0]          cnt_rm;
	logic signed [SUM_W-1:0]   speed_ext;
	logic [SUM_W-1:0]          sum_abs;
	logic [CNT_W:0]            rem_sh;
	logic [CNT_W:0]            rem_diff;
	logic                      rem_ge;
	logic [MEAN_W-1:0]         mean_mag;
	logic signed [MEAN_W-1:0]  mean_s;
	logic [PROD_W-1:0]         prod_abs;
	logic [ADJ_W-1:0]          max_ext;
	logic [ADJ_W-1:0]          mag_lo;
	logic signed [ADJ_W-1:0]   adj;

	assign in_range = ({1'b0, slot_q} < CNT_W'(GENERATORS));
	assign addr     = slot_q[AW-1:0];

	gflc_ram #(
		.WIDTH (SPEED_W),
		.DEPTH (GENERATORS)
	) u_table (
		.clk   (clk),
		.we    (cmd.update && in_range && !open_q),
		.waddr (addr),
		.wdata (speed_q),
		.re    (cmd.read),
		.raddr (addr),
		.rdata (rdata)
	);

	// Take the stored speed out of the sum if the slot is present
	always_comb begin
		old_speed = written_q[addr] ? $signed(rdata) : '0;
		pres_old  = present_q[addr];
		speed_ext = {{(SUM_W - SPEED_W){speed_q[SPEED_W-1]}}, speed_q};
		sum_rm    = pres_old ? sum_q - {{(SUM_W - SPEED_W){old_speed[SPEED_W-1]}}, old_speed}
		                     : sum_q;
		cnt_rm    = pres_old ? cnt_q - CNT_W'(1) : cnt_q;
	end

	// Divider step and arithmetic helpers
	always_comb begin
		sum_abs  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		rem_sh   = {rem_q, quo_q[DIVD_W-1]};
		rem_diff = rem_sh - {1'b0, cnt_q};
		rem_ge   = (rem_sh >= {1'b0, cnt_q});
		mean_mag = quo_q[MEAN_W-1:0];
		mean_s   = sum_neg_q ? $signed(MEAN_W'(0) - mean_mag) : $signed(mean_mag);
		prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	end

	// Clamp to plus or minus the clamp limit; an empty table gives the negative limit
	always_comb begin
		max_ext = {1'b0, max_q};
		mag_lo  = mag_q[ADJ_W-1:0];
		if (cnt_q == '0) begin
			adj = $signed(ADJ_W'(0) - max_ext);
		end else if (mag_q <= MAG_W'(max_q)) begin
			adj = neg_q ? $signed(ADJ_W'(0) - mag_lo) : $signed(mag_lo);
		end else begin
			adj = neg_q ? $signed(ADJ_W'(0) - max_ext) : $signed(max_ext);
		end
	end

	// Capture the measurement
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q  <= slot_index;
			open_q  <= breaker_open;
			speed_q <= rotor_speed;
		end
	end

	// Table bookkeeping and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '1;
			written_q <= '0;
			sum_q     <= '0;
			cnt_q     <= CNT_W'(GENERATORS);
			gain_q    <= GAIN_RST;
			max_q     <= MAXADJ_RST;
		end else begin
			if (cmd.update && in_range) begin
				if (open_q) begin
					present_q[addr] <= 1'b0;
					sum_q           <= sum_rm;
					cnt_q           <= cnt_rm;
				end else begin
					present_q[addr] <= 1'b1;
					written_q[addr] <= 1'b1;
					sum_q           <= sum_rm + speed_ext;
					cnt_q           <= cnt_rm + CNT_W'(1);
				end
			end
			if (cfg_fire) begin
				unique case (cfg_index)
					CFG_GAIN:      gain_q <= $signed(cfg_data[GAIN_W-1:0]);
					CFG_CLAMP_LIM: max_q  <= cfg_data[MAXADJ_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Divide, multiply, magnitude
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			sum_neg_q <= sum_q[SUM_W-1];
			rem_q     <= '0;
			quo_q     <= sum_abs[DIVD_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], rem_ge};
		end
		if (cmd.mult) begin
			prod_q <= mean_s * gain_q;
		end
		if (cmd.absv) begin
			neg_q <= prod_q[PROD_W-1];
			mag_q <= prod_abs[PROD_W-1:FRAC_W];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			last_q      <= '0;
		end else begin
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
				last_q      <= adj;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_adj_q     <= adj;
			res_changed_q <= (adj != last_q);
		end
	end

	assign stat.count_zero = (cnt_q == '0);
	assign stat.out_free   = !res_valid_q || res_ready;

	assign res_valid      = res_valid_q;
	assign res_adjustment = res_adj_q;
	assign res_changed    = res_changed_q;

endmodule

// ----- hw/rtl/grid_frequency_load_controller.sv -----
// A measurement passes through table read, table update, divider preparation,
// the 30-step restoring divider, multiply, magnitude and result load; with no
// slot present it goes from preparation straight to the result load. One
// measurement is in work at a time, the next taken once its result is loaded;
// a finished result waits in the output register while the next is accepted.
// Reset marks every slot present with speed zero, loads the default gain and
// clamp limit; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// grid_frequency_load_controller
// Averages generator rotor speed deviations over present slots, scales by
// the gain and emits a clamped load adjustment with a change flag.
// ----------------------------------------------------------------------------
module grid_frequency_load_controller #(
	parameter int GENERATORS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	gflc_cfg_if.sink  cfg,
	gflc_meas_if.sink meas,
	gflc_res_if.source res
);
	import gflc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     meas_ready;
	logic     meas_fire;

	assign meas.ready = meas_ready;
	assign meas_fire  = meas.valid && meas_ready;
	assign cfg.ready  = 1'b1;

	gflc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_fire  (meas_fire),
		.stat       (stat),
		.cmd        (cmd),
		.meas_ready (meas_ready)
	);

	gflc_dp #(
		.GENERATORS (GENERATORS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.slot_index     (meas.slot_index),
		.breaker_open   (meas.breaker_open),
		.rotor_speed    (meas.rotor_speed),
		.cfg_fire       (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.res_ready      (res.ready),
		.res_valid      (res.valid),
		.res_adjustment (res.adjustment),
		.res_changed    (res.changed)
	);

endmodule

// ----- hw/rtl/gflc_checker.sv -----
// ----------------------------------------------------------------------------
// gflc_checker
// Port-level checks on the load controller, bound to the top level.
// ----------------------------------------------------------------------------
module gflc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       meas_valid,
	input logic                       meas_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [gflc_pkg::ADJ_W-1:0] res_adjustment,
	input logic                       res_changed
);
	import gflc_pkg::*;

	logic [ADJ_W-1:0] prev_adj_q;

	// Track the last delivered adjustment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_adj_q <= '0;
		end else if (res_valid && res_ready) begin
			prev_adj_q <= res_adjustment;
		end
	end

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_adjustment) && $stable(res_changed))
	else $error("result changed while stalled");

	// One measurement in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		meas_valid && meas_ready |=> !meas_ready)
	else $error("measurement accepted while busy");

	// Change flag agrees with the previous delivered adjustment
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |-> res_changed == (res_adjustment != prev_adj_q))
	else $error("change flag disagrees with previous adjustment");

endmodule

bind grid_frequency_load_controller gflc_checker u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.meas_valid     (meas.valid),
	.meas_ready     (meas.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_adjustment (res.adjustment),
	.res_changed    (res.changed)
);

// ----- verif/tb_grid_frequency_load_controller.sv -----
// ----------------------------------------------------------------------------
// tb_grid_frequency_load_controller
// Drives generator measurements and register writes into the load controller
// with random idles and one long result hold-off. A scoreboard keeps its own
// copy of the slot table, running sum and present count, and from these it
// predicts every adjustment and change flag for comparison in arrival order.
// ----------------------------------------------------------------------------
module tb_grid_frequency_load_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import gflc_pkg::*;

	localparam int GENERATORS = 64;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 500;
	localparam int PHASE_ITEMS = 60;

	typedef struct {
		logic signed [ADJ_W-1:0] adjustment;
		logic                    changed;
	} adj_result_t;

	// Slot table mirror and adjustment prediction
	class load_adjust_scoreboard;
		logic signed [SPEED_W-1:0] speed_tab [GENERATORS];
		bit                        present [GENERATORS];
		longint                    speed_sum;
		int                        present_count;
		longint                    last_adj;
		logic signed [GAIN_W-1:0]  gain;
		logic [MAXADJ_W-1:0]       clamp_limit;
		adj_result_t               expected_adj [$];
		int                        errors;

		function new();
			for (int i = 0; i < GENERATORS; i++) begin
				speed_tab[i] = '0;
				present[i] = 1'b1;
			end
			speed_sum = 0;
			present_count = GENERATORS;
			last_adj = 0;
			gain = GAIN_RST;
			clamp_limit = MAXADJ_RST;
			errors = 0;
		endfunction

		function int pending();
			return expected_adj.size();
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// Update the table for one accepted measurement and queue the adjustment
		function void note_measurement(logic [SLOT_W-1:0] slot, logic open,
				logic signed [SPEED_W-1:0] speed);
			adj_result_t r;
			longint      lim;
			longint      mean;
			longint      prod;
			longint      p;
			longint      a;
			if (int'(slot) < GENERATORS) begin
				if (present[slot]) begin
					speed_sum -= longint'(speed_tab[slot]);
					present_count--;
					present[slot] = 1'b0;
					speed_tab[slot] = '0;
				end
				if (!open) begin
					speed_tab[slot] = speed;
					present[slot] = 1'b1;
					speed_sum += longint'(speed);
					present_count++;
				end
			end
			lim = longint'(clamp_limit);
			if (present_count == 0) begin
				a = -lim;
			end else begin
				mean = speed_sum / longint'(present_count);
				prod = mean * longint'(gain);
				// drop the fraction toward zero
				if (prod < 0)
					p = -((-prod) >> FRAC_W);
				else
					p = prod >> FRAC_W;
				if ((p < 0 ? -p : p) <= lim)
					a = p;
				else if (p > 0)
					a = lim;
				else
					a = -lim;
			end
			r.adjustment = a[ADJ_W-1:0];
			r.changed = (a != last_adj);
			last_adj = a;
			expected_adj.push_back(r);
		endfunction

		// Compare one result transaction with the oldest prediction
		task check_result(logic signed [ADJ_W-1:0] adj, logic chg);
			adj_result_t want;
			if (expected_adj.size() == 0) begin
				report_mismatch($sformatf("unexpected result adjustment=%0d changed=%0b",
					adj, chg));
				return;
			end
			want = expected_adj.pop_front();
			if (adj !== want.adjustment)
				report_mismatch($sformatf("adjustment got %0d want %0d", adj,
					want.adjustment));
			if (chg !== want.changed)
				report_mismatch($sformatf("changed got %0b want %0b", chg, want.changed));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   no_idle;
	bit   hold_req;

	gflc_cfg_if  cfg_ch ();
	gflc_meas_if meas_ch ();
	gflc_res_if  res_ch ();

	load_adjust_scoreboard sb;

	grid_frequency_load_controller #(
		.GENERATORS(GENERATORS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.meas(meas_ch),
		.res(res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Small speeds so averages land inside the clamp, with extremes and full-range values mixed in
	function automatic logic signed [SPEED_W-1:0] rand_speed();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2, 3, 4, 5: return SPEED_W'(int'($urandom_range(0, 262143)) - 131072);
			default: return SPEED_W'($urandom());
		endcase
	endfunction

	function automatic logic signed [GAIN_W-1:0] rand_gain();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return '0;
			3, 4, 5, 6: return GAIN_W'(int'($urandom_range(0, 524287)) - 262144);
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	function automatic logic [MAXADJ_W-1:0] rand_clamp_limit();
		int pick;
		pick = $urandom_range(0, 5);
		case (pick)
			0: return '0;
			1: return 16'hFFFF;
			default: return MAXADJ_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Write both registers; valid stays high across the pair
	task automatic write_settings(logic signed [GAIN_W-1:0] g, logic [MAXADJ_W-1:0] m);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_GAIN;
		cfg_ch.data <= g;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.gain = g;
		cfg_ch.index <= CFG_CLAMP_LIM;
		cfg_ch.data <= {{(CFG_DATA_W-MAXADJ_W){1'b0}}, m};
		do @(posedge clk); while (!cfg_ch.ready);
		sb.clamp_limit = m;
		cfg_ch.valid <= 1'b0;
	endtask

	// Offer one measurement, optionally after a random gap
	task automatic send_meas(logic [SLOT_W-1:0] slot, logic open,
			logic signed [SPEED_W-1:0] speed);
		if (!no_idle && $urandom_range(0, 99) < 18) begin
			meas_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		meas_ch.valid <= 1'b1;
		meas_ch.slot_index <= slot;
		meas_ch.breaker_open <= open;
		meas_ch.rotor_speed <= speed;
		do @(posedge clk); while (!meas_ch.ready);
		sb.note_measurement(slot, open, speed);
	endtask

	// Drop valid and hold until every predicted result has come back
	task automatic drain_results();
		meas_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Open every breaker in shuffled order, then poke the empty table
	task automatic empty_table();
		int order [GENERATORS];
		int j;
		int tmp;
		for (int i = 0; i < GENERATORS; i++) order[i] = i;
		for (int i = GENERATORS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < GENERATORS; i++)
			send_meas(SLOT_W'(order[i]), 1'b1, rand_speed());
		repeat (5) send_meas(SLOT_W'($urandom()), 1'b1, rand_speed());
	endtask

	// Result side: check accepted transactions and drive ready
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (res_ch.valid && res_ch.ready)
					sb.check_result(res_ch.adjustment, res_ch.changed);
				if (hold_req && !hold_done) begin
					hold_left = HOLD_CYCLES;
					hold_done = 1'b1;
				end
				if (hold_left > 0) begin
					hold_left--;
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= no_idle || ($urandom_range(0, 99) >= 18);
				end
			end
		end
	end

	// Watchdog: end the run when no channel moves a transaction for too long
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((meas_ch.valid && meas_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("[%0t] watchdog: no transaction for %0d cycles", $realtime, quiet);
				$display("tb_grid_frequency_load_controller: FAIL");
				$finish;
			end
		end
	end

	// Main sequence
	initial begin
		int open_pct;
		sb = new();
		arst_n = 1'b0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		meas_ch.valid = 1'b0;
		meas_ch.slot_index = '0;
		meas_ch.breaker_open = 1'b0;
		meas_ch.rotor_speed = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_GAIN;
		cfg_ch.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed measurements with the reset gain and clamp
		send_meas(6'd0, 1'b0, 24'sh7FFFFF);
		send_meas(6'd63, 1'b0, 24'sh800000);
		send_meas(6'd63, 1'b0, 24'sh800000);
		send_meas(6'd0, 1'b1, 24'sh555555);
		send_meas(6'd0, 1'b1, 24'shAAAAAA);
		send_meas(6'd0, 1'b0, 24'sh000000);
		send_meas(6'h2A, 1'b0, 24'sh000001);
		send_meas(6'h15, 1'b0, 24'shFFFFFF);
		send_meas(6'h2A, 1'b0, 24'sh010000);
		send_meas(6'd63, 1'b1, 24'sh000000);
		send_meas(6'd1, 1'b0, 24'sh0F0F0F);
		send_meas(6'd1, 1'b0, 24'shF0F0F0);
		send_meas(6'd1, 1'b1, 24'sh7FFFFF);
		send_meas(6'd62, 1'b0, 24'sh3FFFFF);
		drain_results();

		// Random phases, each under its own register setting
		for (int k = 0; k < 5; k++) begin
			case (k)
				0: begin
					write_settings(24'sh7FFFFF, 16'hFFFF);
					open_pct = 10;
				end
				1: begin
					write_settings(24'sh800000, 16'h0000);
					open_pct = 40;
				end
				2: begin
					write_settings(24'sh010000, 16'hFFFF);
					no_idle <= 1'b1;
					open_pct = 70;
				end
				3: begin
					write_settings(rand_gain(), rand_clamp_limit());
					no_idle <= 1'b0;
					hold_req <= 1'b1;
					open_pct = 25;
				end
				default: begin
					write_settings(rand_gain(), rand_clamp_limit());
					open_pct = 85;
				end
			endcase
			if (k == 2 || k == 4)
				empty_table();
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_meas(SLOT_W'($urandom()), $urandom_range(0, 99) < open_pct,
					rand_speed());
			drain_results();
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_grid_frequency_load_controller: PASS");
		else
			$display("tb_grid_frequency_load_controller: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/gflc_pkg.sv
hw/rtl/gflc_ifs.sv
hw/rtl/gflc_ram.sv
hw/rtl/gflc_ctrl.sv
hw/rtl/gflc_dp.sv
hw/rtl/grid_frequency_load_controller.sv
hw/rtl/gflc_checker.sv
verif/tb_grid_frequency_load_controller.sv
